// ===== rtl/jfss_pkg.sv =====
// ----------------------------------------------------------------------------
// jfss_pkg
// Beat types, marker codes and scan phase codes for the JPEG frame size scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package jfss_pkg;

  localparam int LEN_BITS = 24;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       first_byte;
  } in_beat_t;

  typedef struct packed {
    logic        frame_found;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } out_beat_t;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_RST7   = 8'hD7;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOF3   = 8'hC3;
  localparam logic [7:0] MK_SOF5   = 8'hC5;
  localparam logic [7:0] MK_SOF7   = 8'hC7;
  localparam logic [7:0] MK_SOF9   = 8'hC9;
  localparam logic [7:0] MK_SOF11  = 8'hCB;
  localparam logic [7:0] MK_SOF13  = 8'hCD;
  localparam logic [7:0] MK_SOF15  = 8'hCF;

  localparam logic [15:0] SEG_LEN_MIN = 16'd2;
  localparam logic [15:0] SOF_LEN_MIN = 16'd7;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_SOI1   = 4'd1;
  localparam logic [3:0] PH_SOI2   = 4'd2;
  localparam logic [3:0] PH_SEARCH = 4'd3;
  localparam logic [3:0] PH_FFRUN  = 4'd4;
  localparam logic [3:0] PH_LENHI  = 4'd5;
  localparam logic [3:0] PH_LENLO  = 4'd6;
  localparam logic [3:0] PH_SKIP   = 4'd7;
  localparam logic [3:0] PH_PREC   = 4'd8;
  localparam logic [3:0] PH_HHI    = 4'd9;
  localparam logic [3:0] PH_HLO    = 4'd10;
  localparam logic [3:0] PH_WHI    = 4'd11;
  localparam logic [3:0] PH_WLO    = 4'd12;
  localparam logic [3:0] PH_DONE   = 4'd13;

  function automatic logic is_standalone(input logic [7:0] m);
    return (m == MK_SOI) || (m == MK_TEM) || (m >= MK_RST0 && m <= MK_RST7);
  endfunction

  function automatic logic is_sof(input logic [7:0] m);
    return (m >= MK_SOF0 && m <= MK_SOF3) || (m >= MK_SOF5 && m <= MK_SOF7) ||
           (m >= MK_SOF9 && m <= MK_SOF11) || (m >= MK_SOF13 && m <= MK_SOF15);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jfss_parse.sv =====
// ----------------------------------------------------------------------------
// jfss_parse
// Marker parser: scan state registers and the per-byte next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

module jfss_parse #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire jfss_pkg::in_beat_t            item,
  input  wire logic [jfss_pkg::LEN_BITS-1:0] stream_length,
  output logic                               res_vld,
  output jfss_pkg::out_beat_t                res
);
  import jfss_pkg::*;

  localparam int SW = (POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS;
  localparam int CW = SW + 2;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [3:0]               phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [SW-1:0]            seg_end_r, seg_end_nxt;
  logic [7:0]               len_hi_r, len_hi_nxt;
  logic                     frm_r, frm_nxt;
  logic [15:0]              hgt_r, hgt_nxt;
  logic [15:0]              wid_r, wid_nxt;

  logic                     active;
  logic [3:0]               phase_c;
  logic [POSITION_BITS-1:0] p;
  logic [CW-1:0]            p_w, size_w, seg_w, start_w, next_w, seg_end_w;
  logic [15:0]              seg;
  logic [7:0]               b;
  logic                     fail, ok;

  assign b         = item.stream_byte;
  assign active    = item.first_byte || (phase_r != PH_IDLE && phase_r < PH_DONE);
  assign phase_c   = item.first_byte ? PH_SOI1 : phase_r;
  assign p         = item.first_byte ? '0 : pos_r;
  assign p_w       = {{(CW-POSITION_BITS){1'b0}}, p};
  assign size_w    = {{(CW-LEN_BITS){1'b0}}, stream_length};
  assign seg       = {len_hi_r, b};
  assign seg_w     = {{(CW-16){1'b0}}, seg};
  assign start_w   = p_w - {{(CW-1){1'b0}}, 1'b1};
  assign next_w    = start_w + seg_w;
  assign seg_end_w = {2'b00, seg_end_r};

  always_comb begin
    phase_nxt   = phase_c;
    seg_end_nxt = item.first_byte ? '0 : seg_end_r;
    len_hi_nxt  = item.first_byte ? '0 : len_hi_r;
    frm_nxt     = item.first_byte ? 1'b0 : frm_r;
    hgt_nxt     = item.first_byte ? '0 : hgt_r;
    wid_nxt     = item.first_byte ? '0 : wid_r;
    fail        = 1'b0;
    ok          = 1'b0;
    unique case (phase_c)
      PH_SOI1: begin
        if (stream_length < LEN_BITS'(4) || b != MK_PREFIX) fail = 1'b1;
        else phase_nxt = PH_SOI2;
      end
      PH_SOI2: begin
        if (b != MK_SOI) fail = 1'b1;
        else phase_nxt = PH_SEARCH;
      end
      PH_SEARCH: begin
        if (b == MK_PREFIX) phase_nxt = PH_FFRUN;
      end
      PH_FFRUN: begin
        priority if (b == MK_PREFIX) begin
          phase_nxt = PH_FFRUN;
        end else if (is_standalone(b)) begin
          if (p_w + CW'(2) >= size_w) fail = 1'b1;
          else phase_nxt = PH_SEARCH;
        end else if (b == MK_EOI || b == MK_SOS || p_w + CW'(2) >= size_w) begin
          fail = 1'b1;
        end else begin
          frm_nxt   = is_sof(b);
          phase_nxt = PH_LENHI;
        end
      end
      PH_LENHI: begin
        len_hi_nxt = b;
        phase_nxt  = PH_LENLO;
      end
      PH_LENLO: begin
        priority if (seg < SEG_LEN_MIN || next_w > size_w) begin
          fail = 1'b1;
        end else if (frm_r) begin
          if (seg < SOF_LEN_MIN) fail = 1'b1;
          else phase_nxt = PH_PREC;
        end else if (next_w + CW'(1) >= size_w) begin
          fail = 1'b1;
        end else if (seg == SEG_LEN_MIN) begin
          phase_nxt = PH_SEARCH;
        end else begin
          seg_end_nxt = next_w[SW-1:0];
          phase_nxt   = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (p_w + CW'(1) >= seg_end_w) phase_nxt = PH_SEARCH;
      end
      PH_PREC: phase_nxt = PH_HHI;
      PH_HHI: begin
        hgt_nxt   = {b, 8'h00};
        phase_nxt = PH_HLO;
      end
      PH_HLO: begin
        hgt_nxt   = {hgt_r[15:8], b};
        phase_nxt = PH_WHI;
      end
      PH_WHI: begin
        wid_nxt   = {b, 8'h00};
        phase_nxt = PH_WLO;
      end
      PH_WLO: begin
        wid_nxt = {wid_r[15:8], b};
        ok      = 1'b1;
      end
      default: phase_nxt = PH_IDLE;
    endcase
    if (!fail && !ok && p_w + CW'(1) >= size_w) fail = 1'b1;
    if (ok || fail) phase_nxt = PH_DONE;
    pos_nxt = (p == POS_MAX) ? p : p + 1'b1;
  end

  assign res_vld = step && active && (ok || fail);

  always_comb begin
    res.frame_found  = 1'b0;
    res.frame_width  = '0;
    res.frame_height = '0;
    if (ok) begin
      res.frame_found  = (wid_nxt != 16'd0) && (hgt_nxt != 16'd0);
      res.frame_width  = wid_nxt;
      res.frame_height = hgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pos_r     <= '0;
      seg_end_r <= '0;
      len_hi_r  <= '0;
      frm_r     <= 1'b0;
      hgt_r     <= '0;
      wid_r     <= '0;
    end else if (step && active) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      seg_end_r <= seg_end_nxt;
      len_hi_r  <= len_hi_nxt;
      frm_r     <= frm_nxt;
      hgt_r     <= hgt_nxt;
      wid_r     <= wid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jpeg_frame_size_scanner.sv =====
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// Scans a JPEG byte stream for the first frame header and reports its size.
//
//   port group | dir | handshake         | payload
//   in_*       | in  | in_valid/in_stall | jfss_pkg::in_beat_t
//   out_*      | out | out_valid/out_stall| jfss_pkg::out_beat_t
//   cfg_*      | in  | cfg_valid/ready   | stream length, 24 bits
//
// one byte per cycle sustained unless out_stall holds a full result register; a
// byte goes through the input register, then the parser and result register
// the rate is set by the parser's state update, made once per byte
// reset clears the scan phase, position and both beat valids
// out_stall holds the result register; the input register keeps taking bytes
// as long as the result register is free or being drained
// ----------------------------------------------------------------------------
`default_nettype none

module jpeg_frame_size_scanner #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire jfss_pkg::in_beat_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output jfss_pkg::out_beat_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [jfss_pkg::LEN_BITS-1:0] cfg_data
);
  import jfss_pkg::*;

  logic                in_vld_r;
  in_beat_t            in_beat_r;
  logic                out_vld_r;
  out_beat_t           out_beat_r;
  logic [LEN_BITS-1:0] stream_len_r;
  logic                adv, in_acc, step, res_vld;
  out_beat_t           res;

  assign adv       = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign step      = in_vld_r && adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

  jfss_parse #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .item         (in_beat_r),
    .stream_length(stream_len_r),
    .res_vld      (res_vld),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      stream_len_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) stream_len_r <= cfg_data;
      if (in_acc) in_vld_r <= 1'b1;
      else if (adv) in_vld_r <= 1'b0;
      if (res_vld) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_beat_r <= in_data;
    if (res_vld) out_beat_r <= res;
  end

endmodule

`default_nettype wire

// ===== rtl/jfss_checker.sv =====
// ----------------------------------------------------------------------------
// jfss_checker
// Port-level checks for the JPEG frame size scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jfss_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire jfss_pkg::out_beat_t out_data
);
  import jfss_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_found |->
      out_data.frame_width != 16'd0 && out_data.frame_height != 16'd0)
    else $error("frame found with a zero dimension");

  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result register");

endmodule

bind jpeg_frame_size_scanner jfss_checker u_jfss_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

// ===== tb/jpeg_frame_size_scanner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner_tb
// Feeds JPEG-like byte streams, one beat per byte, through the scanner under
// several stream length settings and random idling on both sides. A byte-level
// predictor tracks the marker parser and checks every reported frame size.
// ----------------------------------------------------------------------------

module jpeg_frame_size_scanner_tb;
  import jfss_pkg::*;

  localparam int          POS_BITS    = 24;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_BYTES = 175;
  localparam logic [7:0]  SEG_APP0    = 8'hE0;
  localparam longint unsigned POS_MAX = (longint'(1) << POS_BITS) - 1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  in_beat_t            in_data   = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_beat_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LEN_BITS-1:0] cfg_data  = '0;

  in_beat_t  byte_feed[$];
  out_beat_t size_reports[$];

  // predictor state
  logic [LEN_BITS-1:0] scan_len     = '0;
  logic [3:0]          scan_ph      = PH_IDLE;
  longint unsigned     scan_pos     = 0;
  longint unsigned     seg_end      = 0;
  logic [7:0]          len_hi       = '0;
  bit                  in_frame_seg = 1'b0;
  logic [15:0]         hgt          = '0;
  logic [15:0]         wid          = '0;

  bit no_gaps = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int bad_reports = 0;
  int reports_seen = 0;
  int frames_found = 0;
  int bytes_queued = 0;
  int files_queued = 0;
  int length_settings = 0;

  jpeg_frame_size_scanner u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit frame_code(input logic [7:0] m);
    return m[7:4] == MK_SOF0[7:4] && (m[1:0] != 2'b00 || m[3:2] == 2'b00);
  endfunction

  function automatic bit lone_marker(input logic [7:0] m);
    return m == MK_SOI || m == MK_TEM || m[7:3] == MK_RST0[7:3];
  endfunction

  function automatic logic [15:0] pick_dim();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r < 6) return 16'($urandom);
    return 16'($urandom_range(1, 2048));
  endfunction

  task automatic predict_scan(input in_beat_t beat);
    logic [7:0]      b;
    longint unsigned p, seg, start, size;
    bit              fail, ok;
    out_beat_t       r;
    b = beat.stream_byte;
    size = scan_len;
    fail = 1'b0;
    ok = 1'b0;
    p = 0;
    if (beat.first_byte) begin
      scan_ph = PH_SOI1;
      seg_end = 0;
      len_hi = '0;
      in_frame_seg = 1'b0;
      hgt = '0;
      wid = '0;
    end else if (scan_ph == PH_IDLE || scan_ph >= PH_DONE) begin
      return;
    end else begin
      p = scan_pos;
    end
    case (scan_ph)
      PH_SOI1: begin
        if (size < 4 || b != MK_PREFIX) fail = 1'b1;
        else scan_ph = PH_SOI2;
      end
      PH_SOI2: begin
        if (b != MK_SOI) fail = 1'b1;
        else scan_ph = PH_SEARCH;
      end
      PH_SEARCH: begin
        if (b == MK_PREFIX) scan_ph = PH_FFRUN;
      end
      PH_FFRUN: begin
        if (b != MK_PREFIX) begin
          if (lone_marker(b)) begin
            if (p + 2 >= size) fail = 1'b1;
            else scan_ph = PH_SEARCH;
          end else if (b == MK_EOI || b == MK_SOS || p + 2 >= size) begin
            fail = 1'b1;
          end else begin
            in_frame_seg = frame_code(b);
            scan_ph = PH_LENHI;
          end
        end
      end
      PH_LENHI: begin
        len_hi = b;
        scan_ph = PH_LENLO;
      end
      PH_LENLO: begin
        seg = {len_hi, b};
        start = p - 1;
        if (seg < SEG_LEN_MIN || seg + start > size) begin
          fail = 1'b1;
        end else if (in_frame_seg) begin
          if (seg < SOF_LEN_MIN) fail = 1'b1;
          else scan_ph = PH_PREC;
        end else if (start + seg + 1 >= size) begin
          fail = 1'b1;
        end else if (seg == SEG_LEN_MIN) begin
          scan_ph = PH_SEARCH;
        end else begin
          seg_end = start + seg;
          scan_ph = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (p + 1 >= seg_end) scan_ph = PH_SEARCH;
      end
      PH_PREC: scan_ph = PH_HHI;
      PH_HHI: begin
        hgt = {b, 8'h00};
        scan_ph = PH_HLO;
      end
      PH_HLO: begin
        hgt[7:0] = b;
        scan_ph = PH_WHI;
      end
      PH_WHI: begin
        wid = {b, 8'h00};
        scan_ph = PH_WLO;
      end
      PH_WLO: begin
        wid[7:0] = b;
        ok = 1'b1;
      end
      default: begin
        scan_ph = PH_IDLE;
        return;
      end
    endcase
    if (!fail && !ok && p + 1 >= size) fail = 1'b1;
    scan_pos = (p + 1 > POS_MAX) ? POS_MAX : p + 1;
    if (ok || fail) begin
      r = '0;
      if (ok) begin
        r.frame_found = (wid != 0 && hgt != 0);
        r.frame_width = wid;
        r.frame_height = hgt;
      end
      size_reports.push_back(r);
      scan_ph = PH_DONE;
    end
  endtask

  task automatic put_byte(input logic [7:0] b, input logic first);
    in_beat_t beat;
    beat.stream_byte = b;
    beat.first_byte = first;
    byte_feed.push_back(beat);
    bytes_queued++;
    if (first) files_queued++;
  endtask

  task automatic add_file();
    int          i, n, seg;
    logic [7:0]  code;
    logic [15:0] dim_h, dim_w;
    if ($urandom_range(9) < 2) begin
      // noise with stray restarts
      n = $urandom_range(1, 20);
      put_byte(($urandom_range(2) == 0) ? 8'($urandom) : MK_PREFIX, 1'b1);
      for (i = 1; i < n; i++) put_byte(8'($urandom), $urandom_range(15) == 0);
      return;
    end
    put_byte(MK_PREFIX, 1'b1);
    put_byte(($urandom_range(24) == 0) ? 8'($urandom) : MK_SOI, 1'b0);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(5))
        0: put_byte(8'($urandom_range(254)), 1'b0);
        1: begin
          repeat ($urandom_range(1, 3)) put_byte(MK_PREFIX, 1'b0);
          n = $urandom_range(9);
          put_byte(n < 8 ? MK_RST0 + 8'(n) : (n == 8 ? MK_TEM : MK_SOI), 1'b0);
        end
        default: begin
          put_byte(MK_PREFIX, 1'b0);
          put_byte(($urandom_range(9) == 0) ? 8'($urandom) : SEG_APP0 + 8'($urandom_range(15)),
                   1'b0);
          seg = ($urandom_range(11) == 0) ? $urandom_range(65535) : $urandom_range(2, 12);
          put_byte(8'(seg >> 8), 1'b0);
          put_byte(8'(seg), 1'b0);
          n = (seg < 2) ? 0 : (seg > 14 ? 3 : seg - 2);
          repeat (n) put_byte(8'($urandom), 1'b0);
        end
      endcase
    end
    case ($urandom_range(9))
      0: begin
        put_byte(MK_PREFIX, 1'b0);
        put_byte(MK_SOS, 1'b0);
        put_byte(8'($urandom), 1'b0);
      end
      1: begin
        put_byte(MK_PREFIX, 1'b0);
        put_byte(MK_EOI, 1'b0);
      end
      default: begin
        do code = MK_SOF0 | 8'($urandom_range(15)); while (!frame_code(code));
        put_byte(MK_PREFIX, 1'b0);
        put_byte(code, 1'b0);
        seg = ($urandom_range(9) == 0) ? $urandom_range(6) : $urandom_range(7, 17);
        put_byte(8'(seg >> 8), 1'b0);
        put_byte(8'(seg), 1'b0);
        put_byte(8'd8, 1'b0);
        dim_h = pick_dim();
        dim_w = pick_dim();
        put_byte(dim_h[15:8], 1'b0);
        put_byte(dim_h[7:0], 1'b0);
        put_byte(dim_w[15:8], 1'b0);
        put_byte(dim_w[7:0], 1'b0);
        repeat ($urandom_range(0, 2)) put_byte(8'($urandom), 1'b0);
      end
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (byte_feed.size() != 0 || in_valid || size_reports.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scan_len = v;
    length_settings++;
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_scan(in_data);
      if (!in_valid || !in_stall) begin
        if (byte_feed.size() != 0 && (no_gaps || $urandom_range(99) >= 15)) begin
          in_valid <= 1'b1;
          in_data <= byte_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (out_data.frame_found) frames_found++;
        if (size_reports.size() == 0) begin
          bad_reports++;
          $display("%0t: unexpected result found=%0d w=%0d h=%0d", $time,
                   out_data.frame_found, out_data.frame_width, out_data.frame_height);
        end else begin
          want = size_reports.pop_front();
          if (out_data.frame_found !== want.frame_found ||
              out_data.frame_width !== want.frame_width ||
              out_data.frame_height !== want.frame_height) begin
            bad_reports++;
            $display("%0t: mismatch expected found=%0d w=%0d h=%0d, got found=%0d w=%0d h=%0d",
                     $time, want.frame_found, want.frame_width, want.frame_height,
                     out_data.frame_found, out_data.frame_width, out_data.frame_height);
          end
        end
      end
      out_stall <= (hold_left != 0) || (!no_gaps && $urandom_range(99) < 15);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_len[10] = '{24, 5, 40, 64, 200, 1000, 24'hFFFFFF, 0, 100, 48};
    int          i, start_count;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset length is zero: stray byte ignored, then short file
    put_byte(8'h00, 1'b0);
    put_byte(MK_PREFIX, 1'b1);
    wait_idle();
    write_length(24'd4);
    put_byte(8'h00, 1'b1);
    put_byte(MK_PREFIX, 1'b1);
    put_byte(MK_SOI, 1'b0);
    put_byte(MK_PREFIX, 1'b0);
    put_byte(MK_EOI, 1'b0);
    wait_idle();
    write_length(24'hFFFFFF);
    // filler, ff run, restart marker, then a frame with zero width
    put_byte(MK_PREFIX, 1'b1);
    put_byte(MK_SOI, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(MK_PREFIX, 1'b0);
    put_byte(MK_PREFIX, 1'b0);
    put_byte(MK_RST0, 1'b0);
    put_byte(MK_PREFIX, 1'b0);
    put_byte(MK_SOF0, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h08, 1'b0);
    put_byte(8'h08, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h55, 1'b0);

    for (i = 0; i < 10; i++) begin
      wait_idle();
      no_gaps <= (i == 4);
      write_length(i == 7 ? 24'($urandom) : 24'(phase_len[i]));
      if (i == 8) begin
        hold_go <= 1'b1;
        repeat (40) put_byte(8'($urandom_range(254)), 1'b1);
      end
      start_count = bytes_queued;
      while (bytes_queued - start_count < PHASE_BYTES) add_file();
    end
    wait_idle();

    $display("%0d bytes in %0d files over %0d stream length settings", bytes_queued,
             files_queued, length_settings);
    $display("%0d scan results checked, %0d with a frame size found", reports_seen,
             frames_found);
    if (bad_reports == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
